// ===== hw/rtl/hbc_pkg.sv =====
`default_nettype none

package hbc_pkg;

  localparam int unsigned DefBins      = 1024;
  localparam int unsigned DefCountBits = 32;

  localparam int unsigned DataW      = 16;
  localparam int unsigned WideW      = DataW + 1;
  localparam int unsigned SumW       = 32;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned QueueDepth = 2;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_QUERY = 2'd1,
    OP_CLEAR = 2'd2
  } op_e;

  localparam logic [CfgIdxW-1:0] CfgRangeLow  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgRangeHigh = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgBinWidth  = 2'd2;

  localparam logic signed [DataW-1:0] RangeLowRst  = 16'sd0;
  localparam logic signed [DataW-1:0] RangeHighRst = 16'sd100;
  localparam logic [DataW-1:0]        BinWidthRst  = 16'd1;

  typedef struct packed {
    op_e              op;
    logic             nobins;
    logic [DataW-1:0] a_diff;
    logic             a_ge;
    logic             a_le;
    logic [DataW-1:0] b_diff;
    logic             b_ge;
    logic             b_le;
    logic [DataW-1:0] span_diff;
    logic             span_ok;
  } item_t;

  localparam int unsigned ItemW = $bits(item_t);

endpackage

`default_nettype wire

// ===== hw/rtl/histogram_bin_counter_range_query.sv =====
// Histogram of BINS saturating counters over [range_low, range_high]. An item
// is taken when start is high and busy is low; each item yields exactly one
// result, shown for one cycle with done_o, and the receiver cannot stall it.
// A two-entry queue lets items be taken while an earlier one is at work. An add
// runs the shift-subtract divider, then reads and increments one counter; a
// query runs three divisions, then sums the bins, one counter memory read
// each; a clear writes one memory row per cycle. After reset the block clears
// the memory with busy high. Configuration writes are always ready and must
// come only while idle.
`default_nettype none

module histogram_bin_counter_range_query #(
  parameter int unsigned BINS       = hbc_pkg::DefBins,
  parameter int unsigned COUNT_BITS = hbc_pkg::DefCountBits
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic [1:0]                       operation_i,
  input  wire logic signed [hbc_pkg::DataW-1:0] sample_i,
  input  wire logic signed [hbc_pkg::DataW-1:0] query_low_i,
  input  wire logic signed [hbc_pkg::DataW-1:0] query_high_i,
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [hbc_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  wire logic [hbc_pkg::DataW-1:0]        cfg_data_i,
  output logic                                  done_o,
  output logic      [hbc_pkg::SumW-1:0]         pixel_count_o,
  output logic                                  counted_o,
  output logic                                  dropped_o
);

  logic                         push, pop, q_full, q_empty, init;
  hbc_pkg::item_t               front_item, back_item;
  logic [hbc_pkg::DataW-1:0]    bin_width;

  hbc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .operation_i  (operation_i),
    .sample_i     (sample_i),
    .query_low_i  (query_low_i),
    .query_high_i (query_high_i),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .queue_full_i (q_full),
    .init_i       (init),
    .busy         (busy),
    .push_o       (push),
    .item_o       (front_item),
    .bin_width_o  (bin_width)
  );

  hbc_queue #(
    .Width (hbc_pkg::ItemW),
    .Depth (hbc_pkg::QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_item),
    .pop_i   (pop),
    .data_o  (back_item),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  hbc_back #(
    .Bins      (BINS),
    .CountBits (COUNT_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .empty_i       (q_empty),
    .item_i        (back_item),
    .pop_o         (pop),
    .bin_width_i   (bin_width),
    .init_o        (init),
    .done_o        (done_o),
    .pixel_count_o (pixel_count_o),
    .counted_o     (counted_o),
    .dropped_o     (dropped_o)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/hbc_ram.sv =====
`default_nettype none

module hbc_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  wire logic                                       clk_i,
  input  wire logic                                       we_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  wire logic [Width-1:0]                           wdata_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic      [Width-1:0]                           rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/hbc_div.sv =====
`default_nettype none

module hbc_div (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  input  wire logic [hbc_pkg::DataW-1:0] dividend_i,
  input  wire logic [hbc_pkg::DataW-1:0] divisor_i,
  output logic                          done_o,
  output logic      [hbc_pkg::DataW-1:0] quotient_o
);

  localparam int unsigned W  = hbc_pkg::DataW;
  localparam int unsigned CW = $clog2(W + 1);

  logic [CW-1:0] cnt_q, cnt_d;
  logic [W-1:0]  quo_q, quo_d;
  logic [W-1:0]  rem_q, rem_d;
  logic [W-1:0]  dvs_q, dvs_d;
  logic          done_q, done_d;
  logic [W:0]    shifted;
  logic [W:0]    trial;

  always_comb begin
    shifted = {rem_q, quo_q[W-1]};
    trial   = shifted - {1'b0, dvs_q};
    cnt_d   = cnt_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    dvs_d   = dvs_q;
    done_d  = 1'b0;
    if (start_i) begin
      cnt_d = CW'(W);
      quo_d = dividend_i;
      rem_d = '0;
      dvs_d = divisor_i;
    end else if (cnt_q != '0) begin
      cnt_d  = cnt_q - CW'(1);
      done_d = (cnt_q == CW'(1));
      if (!trial[W]) begin
        rem_d = trial[W-1:0];
        quo_d = {quo_q[W-2:0], 1'b1};
      end else begin
        rem_d = shifted[W-1:0];
        quo_d = {quo_q[W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

// ===== hw/rtl/hbc_queue.sv =====
`default_nettype none

module hbc_queue #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] data_i,
  input  wire logic             pop_i,
  output logic      [Width-1:0] data_o,
  output logic                  full_o,
  output logic                  empty_o
);

  localparam int unsigned PW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PW-1:0]    wr_q, rd_q;
  logic [CW-1:0]    cnt_q;

  function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
    return (p == PW'(Depth - 1)) ? '0 : p + PW'(1);
  endfunction

  assign full_o  = (cnt_q == CW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= next_ptr(wr_q);
      end
      if (pop_i) begin
        rd_q <= next_ptr(rd_q);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/hbc_front.sv =====
`default_nettype none

module hbc_front (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  input  wire logic [1:0]                    operation_i,
  input  wire logic signed [hbc_pkg::DataW-1:0] sample_i,
  input  wire logic signed [hbc_pkg::DataW-1:0] query_low_i,
  input  wire logic signed [hbc_pkg::DataW-1:0] query_high_i,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [hbc_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [hbc_pkg::DataW-1:0]     cfg_data_i,
  input  wire logic                          queue_full_i,
  input  wire logic                          init_i,
  output logic                               busy,
  output logic                               push_o,
  output hbc_pkg::item_t                     item_o,
  output logic      [hbc_pkg::DataW-1:0]     bin_width_o
);

  localparam int unsigned W = hbc_pkg::DataW;

  logic signed [W-1:0] range_low_q, range_high_q;
  logic [W-1:0]        bin_width_q;
  hbc_pkg::op_e        op;
  logic signed [W-1:0] a_val;
  logic [W:0]          a_d, b_d, span_d;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_low_q  <= hbc_pkg::RangeLowRst;
      range_high_q <= hbc_pkg::RangeHighRst;
      bin_width_q  <= hbc_pkg::BinWidthRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        hbc_pkg::CfgRangeLow:  range_low_q  <= cfg_data_i;
        hbc_pkg::CfgRangeHigh: range_high_q <= cfg_data_i;
        hbc_pkg::CfgBinWidth:  bin_width_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Differences are taken over sign-extended operands, so bit W is the sign.
  always_comb begin
    op     = hbc_pkg::op_e'(operation_i);
    a_val  = (op == hbc_pkg::OP_ADD) ? sample_i : query_low_i;
    a_d    = {a_val[W-1], a_val} - {range_low_q[W-1], range_low_q};
    b_d    = {query_high_i[W-1], query_high_i} - {range_low_q[W-1], range_low_q};
    span_d = {range_high_q[W-1], range_high_q} - {range_low_q[W-1], range_low_q};

    item_o.op        = op;
    item_o.nobins    = (bin_width_q == '0);
    item_o.a_diff    = a_d[W-1:0];
    item_o.a_ge      = !a_d[W];
    item_o.a_le      = (a_val <= range_high_q);
    item_o.b_diff    = b_d[W-1:0];
    item_o.b_ge      = !b_d[W];
    item_o.b_le      = (query_high_i <= range_high_q);
    item_o.span_diff = span_d[W-1:0];
    item_o.span_ok   = !span_d[W];
  end

  assign busy        = queue_full_i || init_i;
  assign push_o      = start && !busy;
  assign bin_width_o = bin_width_q;

endmodule

`default_nettype wire

// ===== hw/rtl/hbc_back.sv =====
`default_nettype none

module hbc_back #(
  parameter int unsigned Bins      = hbc_pkg::DefBins,
  parameter int unsigned CountBits = hbc_pkg::DefCountBits
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      empty_i,
  input  hbc_pkg::item_t                 item_i,
  output logic                           pop_o,
  input  wire logic [hbc_pkg::DataW-1:0] bin_width_i,
  output logic                           init_o,
  output logic                           done_o,
  output logic      [hbc_pkg::SumW-1:0]  pixel_count_o,
  output logic                           counted_o,
  output logic                           dropped_o
);

  localparam int unsigned W   = hbc_pkg::DataW;
  localparam int unsigned WW  = hbc_pkg::WideW;
  localparam int unsigned OW  = hbc_pkg::SumW;
  localparam int unsigned AW  = (Bins > 1) ? $clog2(Bins) : 1;
  localparam int unsigned AccW = ((CountBits > OW) ? CountBits : OW) + 1;
  localparam logic [WW-1:0] BinsL    = WW'(Bins);
  localparam logic [WW-1:0] LastAddr = WW'(Bins - 1);

  localparam logic [2:0] SIdle  = 3'd0;
  localparam logic [2:0] SDiv   = 3'd1;
  localparam logic [2:0] SAddRd = 3'd2;
  localparam logic [2:0] SAddWr = 3'd3;
  localparam logic [2:0] SQRd   = 3'd4;
  localparam logic [2:0] SQAcc  = 3'd5;
  localparam logic [2:0] SClr   = 3'd6;

  localparam logic [1:0] PhSpan  = 2'd0;
  localparam logic [1:0] PhFirst = 2'd1;
  localparam logic [1:0] PhLast  = 2'd2;

  logic [2:0]           state_q, state_d;
  logic [1:0]           phase_q, phase_d;
  logic                 init_q, init_d;
  hbc_pkg::item_t       item_q, item_d;
  logic [WW-1:0]        addr_q, addr_d;
  logic [WW-1:0]        used_q, used_d;
  logic [WW-1:0]        last_q, last_d;
  logic [OW-1:0]        sum_q, sum_d;
  logic                 done_q, done_d;
  logic [OW-1:0]        pixel_q, pixel_d;
  logic                 counted_q, counted_d;
  logic                 dropped_q, dropped_d;

  logic                 div_start, div_done;
  logic [W-1:0]         div_dvd, div_quo;
  logic                 ram_we;
  logic [CountBits-1:0] ram_wdata, ram_rdata;

  logic [WW-1:0]        q_wide, q_inc, used_calc, last_raw, last_calc, addr_inc;
  logic [AccW-1:0]      acc;

  hbc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (bin_width_i),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  hbc_ram #(
    .Width (CountBits),
    .Depth (Bins)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (addr_q[AW-1:0]),
    .wdata_i (ram_wdata),
    .raddr_i (addr_q[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    q_wide    = {1'b0, div_quo};
    q_inc     = q_wide + WW'(1);
    used_calc = (q_inc > BinsL) ? BinsL : q_inc;
    last_raw  = item_q.b_le ? q_wide : used_q;
    last_calc = (last_raw > used_q) ? used_q : last_raw;
    addr_inc  = addr_q + WW'(1);
    acc       = AccW'(sum_q) + AccW'(ram_rdata);

    state_d   = state_q;
    phase_d   = phase_q;
    init_d    = init_q;
    item_d    = item_q;
    addr_d    = addr_q;
    used_d    = used_q;
    last_d    = last_q;
    sum_d     = sum_q;
    done_d    = 1'b0;
    pixel_d   = pixel_q;
    counted_d = counted_q;
    dropped_d = dropped_q;
    pop_o     = 1'b0;
    div_start = 1'b0;
    div_dvd   = '0;
    ram_we    = 1'b0;
    ram_wdata = '0;

    unique case (state_q)
      SIdle: begin
        if (!empty_i) begin
          pop_o     = 1'b1;
          item_d    = item_i;
          pixel_d   = '0;
          counted_d = 1'b0;
          dropped_d = 1'b0;
          sum_d     = '0;
          unique case (item_i.op)
            hbc_pkg::OP_ADD: begin
              if (item_i.nobins || !item_i.a_ge || !item_i.a_le) begin
                done_d = 1'b1;
              end else begin
                div_start = 1'b1;
                div_dvd   = item_i.a_diff;
                state_d   = SDiv;
              end
            end
            hbc_pkg::OP_QUERY: begin
              if (item_i.nobins) begin
                done_d = 1'b1;
              end else begin
                div_start = 1'b1;
                div_dvd   = item_i.span_diff;
                phase_d   = PhSpan;
                state_d   = SDiv;
              end
            end
            hbc_pkg::OP_CLEAR: begin
              addr_d  = '0;
              state_d = SClr;
            end
            default: done_d = 1'b1;
          endcase
        end
      end
      SDiv: begin
        if (div_done) begin
          if (item_q.op == hbc_pkg::OP_ADD) begin
            if (q_wide >= BinsL) begin
              dropped_d = 1'b1;
              done_d    = 1'b1;
              state_d   = SIdle;
            end else begin
              addr_d  = q_wide;
              state_d = SAddRd;
            end
          end else begin
            unique case (phase_q)
              PhSpan: begin
                used_d    = item_q.span_ok ? used_calc : '0;
                div_start = 1'b1;
                div_dvd   = item_q.a_ge ? item_q.a_diff : '0;
                phase_d   = PhFirst;
              end
              PhFirst: begin
                addr_d    = q_wide;
                div_start = 1'b1;
                div_dvd   = item_q.b_ge ? item_q.b_diff : '0;
                phase_d   = PhLast;
              end
              PhLast: begin
                last_d = last_calc;
                if (addr_q >= last_calc) begin
                  pixel_d = '0;
                  done_d  = 1'b1;
                  state_d = SIdle;
                end else begin
                  state_d = SQRd;
                end
              end
              default: state_d = SIdle;
            endcase
          end
        end
      end
      SAddRd: state_d = SAddWr;
      SAddWr: begin
        ram_we    = 1'b1;
        ram_wdata = (&ram_rdata) ? ram_rdata : ram_rdata + CountBits'(1);
        counted_d = 1'b1;
        done_d    = 1'b1;
        state_d   = SIdle;
      end
      SQRd: state_d = SQAcc;
      SQAcc: begin
        addr_d = addr_inc;
        if (|acc[AccW-1:OW]) begin
          sum_d   = '1;
          pixel_d = '1;
          done_d  = 1'b1;
          state_d = SIdle;
        end else begin
          sum_d = acc[OW-1:0];
          if (addr_inc >= last_q) begin
            pixel_d = acc[OW-1:0];
            done_d  = 1'b1;
            state_d = SIdle;
          end else begin
            state_d = SQRd;
          end
        end
      end
      SClr: begin
        ram_we = 1'b1;
        addr_d = addr_inc;
        if (addr_q == LastAddr) begin
          state_d = SIdle;
          if (init_q) begin
            init_d = 1'b0;
          end else begin
            done_d = 1'b1;
          end
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SClr;
      init_q  <= 1'b1;
      addr_q  <= '0;
      phase_q <= PhSpan;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      init_q  <= init_d;
      addr_q  <= addr_d;
      phase_q <= phase_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q    <= item_d;
    used_q    <= used_d;
    last_q    <= last_d;
    sum_q     <= sum_d;
    pixel_q   <= pixel_d;
    counted_q <= counted_d;
    dropped_q <= dropped_d;
  end

  assign init_o        = init_q;
  assign done_o        = done_q;
  assign pixel_count_o = pixel_q;
  assign counted_o     = counted_q;
  assign dropped_o     = dropped_q;

endmodule

`default_nettype wire

// ===== hw/rtl/hbc_checker.sv =====
`default_nettype none

module hbc_checker (
  input wire logic                     clk_i,
  input wire logic                     rst_ni,
  input wire logic                     start,
  input wire logic                     busy,
  input wire logic                     done_o,
  input wire logic [hbc_pkg::SumW-1:0] pixel_count_o,
  input wire logic                     counted_o,
  input wire logic                     dropped_o
);

  logic [2:0] owed_q;
  logic       accept;

  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owed_q <= '0;
    end else if (accept && !done_o) begin
      owed_q <= owed_q + 3'd1;
    end else if (done_o && !accept) begin
      owed_q <= owed_q - 3'd1;
    end
  end

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(counted_o && dropped_o))
    else $error("counted and dropped both set");

  a_add_no_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (counted_o || dropped_o) |-> pixel_count_o == '0)
    else $error("add result carries a nonzero count");

  a_result_owed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> owed_q != 3'd0)
    else $error("result without an outstanding transfer");

endmodule

bind histogram_bin_counter_range_query hbc_checker u_checker (.*);

`default_nettype wire
